/* sv/stick_trigger_sqrt_response_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the joystick response block
// Shared property templates, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STICK_TRIGGER_SQRT_RESPONSE_ASSERT_SVH
`define STICK_TRIGGER_SQRT_RESPONSE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/stsr_pkg.sv */
// ----------------------------------------------------------------------------
// stsr_pkg
// Shared types, register indexes and curve constants of the response block.
// ----------------------------------------------------------------------------
`default_nettype none

package stsr_pkg;

  // Sample width limits and defaults.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int SAMPLE_MAX_BITS = 16;

  // Configuration port geometry.
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  // Datapath widths.
  localparam int AXIS_W    = 16;
  localparam int KSQ_W     = 31;
  localparam int QUO_W     = 31;
  localparam int ROOT_W    = 16;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQ_REM_W  = 18;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_MODE    = 3'd0,
    REG_CAL_LOW       = 3'd1,
    REG_CAL_CENTER    = 3'd2,
    REG_CAL_HIGH      = 3'd3,
    REG_OUTPUT_ENABLE = 3'd4
  } reg_idx_t;

  // Curve modes.
  localparam logic MODE_STICK   = 1'b0;
  localparam logic MODE_TRIGGER = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] CAL_LOW_RST    = 12'd0;
  localparam logic [CFG_W-1:0] CAL_CENTER_RST = 12'd2048;
  localparam logic [CFG_W-1:0] CAL_HIGH_RST   = 12'd4095;

  // Squared full-scale factors of the three curve branches.
  typedef enum logic [1:0] {
    KSEL_NEG  = 2'd0,
    KSEL_POS  = 2'd1,
    KSEL_TRIG = 2'd2
  } ksel_t;

  localparam logic [KSQ_W-1:0] KSQ_NEG  = 31'd1073741824; // 32768^2
  localparam logic [KSQ_W-1:0] KSQ_POS  = 31'd1073676289; // 32767^2
  localparam logic [KSQ_W-1:0] KSQ_TRIG = 31'd65025;      // 255^2

  // Fixed report values.
  localparam logic signed [AXIS_W-1:0] AXIS_MIN  = 16'sh8000;
  localparam logic signed [AXIS_W-1:0] AXIS_MAX  = 16'sh7FFF;
  localparam logic signed [AXIS_W-1:0] TRIG_MAX  = 16'sh00FF;
  localparam logic signed [AXIS_W-1:0] AXIS_ZERO = 16'sh0000;

  // Configuration register set.
  typedef struct packed {
    logic             curve_mode;
    logic [CFG_W-1:0] cal_low;
    logic [CFG_W-1:0] cal_center;
    logic [CFG_W-1:0] cal_high;
    logic             output_enable;
  } cfg_t;

  // Sideband that rides with every beat down the pipeline.
  typedef struct packed {
    logic                     byp;
    logic signed [AXIS_W-1:0] byp_val;
    logic                     neg;
  } side_t;

endpackage

`default_nettype wire

/* sv/stick_trigger_sqrt_response.sv */
// ----------------------------------------------------------------------------
// stick_trigger_sqrt_response
// Maps a calibrated analog-axis sample to a report value on a square-root
// response curve.
//
// Usage:
//   Samples enter on in_valid/in_ready with in_adc_sample; results leave on
//   out_valid/out_ready with out_axis_value (signed stick position, or a
//   trigger depth 0..255). Registers are written on cfg_we with cfg_index
//   and cfg_data; the user must write them only while no beat is in
//   flight, which the block itself does not enforce. Every beat crosses
//   50 register stages: two front stages (classify and scale), 31 divider
//   stages (one quotient bit each), 16 square-root stages (one root bit
//   each) and the output register. Throughput is one beat per cycle while
//   out_ready stays high; the per-stage handshake lets new beats fill
//   empty stages while the output holds.
//   When the receiver stalls, the output holds its beat and stages fill up
//   behind it; in_ready drops only once every stage is occupied.
//   Synchronous reset empties the pipeline and restores the register
//   defaults (stick mode, 0/2048/4095 calibration, output disabled).
// ----------------------------------------------------------------------------
`default_nettype none

module stick_trigger_sqrt_response #(
  parameter int SAMPLE_BITS = stsr_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [SAMPLE_BITS-1:0]            in_adc_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [stsr_pkg::AXIS_W-1:0]     out_axis_value,
  input  wire logic                              cfg_we,
  input  wire logic [stsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stsr_pkg::CFG_W-1:0]        cfg_data
);
  import stsr_pkg::*;

  localparam int NUM_W = SAMPLE_BITS + KSQ_W - 1;

  cfg_t cfg_r, cfg_nxt;

  logic                   div_v    [0:QUO_W];
  logic                   div_rdy  [0:QUO_W];
  side_t                  div_side [0:QUO_W];
  logic [SAMPLE_BITS-1:0] div_den  [0:QUO_W];
  logic [SAMPLE_BITS-1:0] div_rem  [0:QUO_W];
  logic [QUO_W-1:0]       div_quo  [0:QUO_W];
  logic [NUM_W-1:0]       front_num;

  logic                sq_v    [0:ROOT_W];
  logic                sq_rdy  [0:ROOT_W];
  side_t               sq_side [0:ROOT_W];
  logic [RAD_W-1:0]    sq_rad  [0:ROOT_W];
  logic [SQ_REM_W-1:0] sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   sq_root [0:ROOT_W];

  logic                     out_valid_r;
  logic signed [AXIS_W-1:0] out_axis_value_r, out_axis_value_nxt;
  logic                     out_load;

  // Configuration register file.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CURVE_MODE:    cfg_nxt.curve_mode    = cfg_data[0];
        REG_CAL_LOW:       cfg_nxt.cal_low       = cfg_data;
        REG_CAL_CENTER:    cfg_nxt.cal_center    = cfg_data;
        REG_CAL_HIGH:      cfg_nxt.cal_high      = cfg_data;
        REG_OUTPUT_ENABLE: cfg_nxt.output_enable = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve_mode    <= MODE_STICK;
      cfg_r.cal_low       <= CAL_LOW_RST;
      cfg_r.cal_center    <= CAL_CENTER_RST;
      cfg_r.cal_high      <= CAL_HIGH_RST;
      cfg_r.output_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classification and numerator scaling.
  stsr_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_W       (NUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_adc_sample),
    .out_valid (div_v[0]),
    .out_ready (div_rdy[0]),
    .out_side  (div_side[0]),
    .out_num   (front_num),
    .out_den   (div_den[0])
  );

  // The quotient fits in QUO_W bits, so the upper dividend bits are
  // already below the divisor and start as the partial remainder.
  assign div_rem[0] = SAMPLE_BITS'(front_num[NUM_W-1:QUO_W]);
  assign div_quo[0] = front_num[QUO_W-1:0];

  // Divider pipeline.
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    stsr_div_step #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[i]),
      .in_ready  (div_rdy[i]),
      .in_side   (div_side[i]),
      .in_den    (div_den[i]),
      .in_rem    (div_rem[i]),
      .in_quo    (div_quo[i]),
      .out_valid (div_v[i+1]),
      .out_ready (div_rdy[i+1]),
      .out_side  (div_side[i+1]),
      .out_den   (div_den[i+1]),
      .out_rem   (div_rem[i+1]),
      .out_quo   (div_quo[i+1])
    );
  end

  // Hand the quotient to the root pipeline.
  assign sq_v[0]         = div_v[QUO_W];
  assign div_rdy[QUO_W]  = sq_rdy[0];
  assign sq_side[0]      = div_side[QUO_W];
  assign sq_rad[0]       = RAD_W'(div_quo[QUO_W]);
  assign sq_rem[0]       = '0;
  assign sq_root[0]      = '0;

  // Square-root pipeline.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    stsr_sqrt_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[j]),
      .in_ready  (sq_rdy[j]),
      .in_side   (sq_side[j]),
      .in_rad    (sq_rad[j]),
      .in_rem    (sq_rem[j]),
      .in_root   (sq_root[j]),
      .out_valid (sq_v[j+1]),
      .out_ready (sq_rdy[j+1]),
      .out_side  (sq_side[j+1]),
      .out_rad   (sq_rad[j+1]),
      .out_rem   (sq_rem[j+1]),
      .out_root  (sq_root[j+1])
    );
  end

  // Output register: apply sign or substitute the bypass value (a saturated end or zero).
  always_comb begin
    if (sq_side[ROOT_W].byp) begin
      out_axis_value_nxt = sq_side[ROOT_W].byp_val;
    end else if (sq_side[ROOT_W].neg) begin
      out_axis_value_nxt = $signed(ROOT_W'(0) - sq_root[ROOT_W]);
    end else begin
      out_axis_value_nxt = $signed(sq_root[ROOT_W]);
    end
  end

  assign out_load       = !out_valid_r || out_ready;
  assign sq_rdy[ROOT_W] = out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && sq_v[ROOT_W]) begin
      out_axis_value_r <= out_axis_value_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_axis_value = out_axis_value_r;

endmodule

`default_nettype wire

/* sv/stsr_front.sv */
// ----------------------------------------------------------------------------
// stsr_front
// Classifies a sample against the calibration points, then scales the
// numerator by the squared full-scale factor. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module stsr_front #(
  parameter int SAMPLE_BITS = stsr_pkg::SAMPLE_BITS_DEF,
  parameter int NUM_W       = SAMPLE_BITS + stsr_pkg::KSQ_W - 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire stsr_pkg::cfg_t         cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output stsr_pkg::side_t             out_side,
  output logic [NUM_W-1:0]            out_num,
  output logic [SAMPLE_BITS-1:0]      out_den
);
  import stsr_pkg::*;

  logic [SAMPLE_MAX_BITS-1:0] lo_ext, mid_ext, hi_ext;
  logic [SAMPLE_BITS-1:0]     lo, mid, hi;

  logic                   v0_r;
  side_t                  side0_r, side0_nxt;
  logic [SAMPLE_BITS-1:0] n0_r, n0_nxt;
  logic [SAMPLE_BITS-1:0] d0_r, d0_nxt;
  ksel_t                  ksel0_r, ksel0_nxt;
  logic                   rdy0;

  logic                         v1_r;
  side_t                        side1_r;
  logic [NUM_W-1:0]             num1_r, num1_nxt;
  logic [SAMPLE_BITS-1:0]       d1_r;
  logic                         rdy1;
  logic [KSQ_W-1:0]             ksq;
  logic [SAMPLE_BITS+KSQ_W-1:0] prod;

  // Calibration points reduced to the sample width.
  always_comb begin
    lo_ext  = SAMPLE_MAX_BITS'(cfg.cal_low);
    mid_ext = SAMPLE_MAX_BITS'(cfg.cal_center);
    hi_ext  = SAMPLE_MAX_BITS'(cfg.cal_high);
    lo      = lo_ext[SAMPLE_BITS-1:0];
    mid     = mid_ext[SAMPLE_BITS-1:0];
    hi      = hi_ext[SAMPLE_BITS-1:0];
  end

  // Branch selection: saturated ends and disabled output bypass the divider and root.
  always_comb begin
    side0_nxt         = '0;
    n0_nxt            = '0;
    d0_nxt            = '0;
    ksel0_nxt         = KSEL_TRIG;
    if (!cfg.output_enable) begin
      side0_nxt.byp     = 1'b1;
      side0_nxt.byp_val = AXIS_ZERO;
    end else if (cfg.curve_mode == MODE_STICK) begin
      if (in_sample < lo) begin
        side0_nxt.byp     = 1'b1;
        side0_nxt.byp_val = AXIS_MIN;
      end else if (in_sample < mid) begin
        side0_nxt.neg = 1'b1;
        n0_nxt        = mid - in_sample;
        d0_nxt        = mid - lo;
        ksel0_nxt     = KSEL_NEG;
      end else if (in_sample < hi) begin
        n0_nxt    = in_sample - mid;
        d0_nxt    = hi - mid;
        ksel0_nxt = KSEL_POS;
      end else begin
        side0_nxt.byp     = 1'b1;
        side0_nxt.byp_val = AXIS_MAX;
      end
    end else begin
      if (in_sample < lo) begin
        side0_nxt.byp     = 1'b1;
        side0_nxt.byp_val = AXIS_ZERO;
      end else if (in_sample < hi) begin
        n0_nxt    = in_sample - lo;
        d0_nxt    = hi - lo;
        ksel0_nxt = KSEL_TRIG;
      end else begin
        side0_nxt.byp     = 1'b1;
        side0_nxt.byp_val = TRIG_MAX;
      end
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor moves.
  assign rdy1     = !v1_r || out_ready;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      side0_r <= side0_nxt;
      n0_r    <= n0_nxt;
      d0_r    <= d0_nxt;
      ksel0_r <= ksel0_nxt;
    end
  end

  // Squared scale factor for the chosen branch.
  always_comb begin
    unique case (ksel0_r)
      KSEL_NEG:  ksq = KSQ_NEG;
      KSEL_POS:  ksq = KSQ_POS;
      KSEL_TRIG: ksq = KSQ_TRIG;
      default:   ksq = KSQ_TRIG;
    endcase
  end

  // Numerator times K squared; the product never reaches the top bit.
  assign prod     = {{KSQ_W{1'b0}}, n0_r} * {{SAMPLE_BITS{1'b0}}, ksq};
  assign num1_nxt = prod[NUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      side1_r <= side0_r;
      num1_r  <= num1_nxt;
      d1_r    <= d0_r;
    end
  end

  assign out_valid = v1_r;
  assign out_side  = side1_r;
  assign out_num   = num1_r;
  assign out_den   = d1_r;

endmodule

`default_nettype wire

/* sv/stsr_div_step.sv */
// ----------------------------------------------------------------------------
// stsr_div_step
// One restoring-division stage: produces one quotient bit per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module stsr_div_step #(
  parameter int SAMPLE_BITS = stsr_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire stsr_pkg::side_t           in_side,
  input  wire logic [SAMPLE_BITS-1:0]    in_den,
  input  wire logic [SAMPLE_BITS-1:0]    in_rem,
  input  wire logic [stsr_pkg::QUO_W-1:0] in_quo,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output stsr_pkg::side_t                out_side,
  output logic [SAMPLE_BITS-1:0]         out_den,
  output logic [SAMPLE_BITS-1:0]         out_rem,
  output logic [stsr_pkg::QUO_W-1:0]     out_quo
);
  import stsr_pkg::*;

  logic [SAMPLE_BITS:0]   trial, diff;
  logic                   ge;
  logic                   v_r;
  side_t                  side_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [SAMPLE_BITS-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]       quo_r, quo_nxt;

  // Bring down the next dividend bit and try to subtract the divisor.
  // The quotient register shifts dividend bits out and quotient bits in.
  always_comb begin
    trial   = {in_rem, in_quo[QUO_W-1]};
    diff    = trial - {1'b0, in_den};
    ge      = (trial >= {1'b0, in_den});
    rem_nxt = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
    quo_nxt = {in_quo[QUO_W-2:0], ge};
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side_r <= in_side;
      den_r  <= in_den;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_side  = side_r;
  assign out_den   = den_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;

endmodule

`default_nettype wire

/* sv/stsr_sqrt_step.sv */
// ----------------------------------------------------------------------------
// stsr_sqrt_step
// One digit-by-digit square-root stage: produces one root bit per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module stsr_sqrt_step (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire stsr_pkg::side_t               in_side,
  input  wire logic [stsr_pkg::RAD_W-1:0]    in_rad,
  input  wire logic [stsr_pkg::SQ_REM_W-1:0] in_rem,
  input  wire logic [stsr_pkg::ROOT_W-1:0]   in_root,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output stsr_pkg::side_t                    out_side,
  output logic [stsr_pkg::RAD_W-1:0]         out_rad,
  output logic [stsr_pkg::SQ_REM_W-1:0]      out_rem,
  output logic [stsr_pkg::ROOT_W-1:0]        out_root
);
  import stsr_pkg::*;

  logic [SQ_REM_W+1:0] shifted, trial, diff;
  logic                ge;
  logic                v_r;
  side_t               side_r;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  logic [SQ_REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;

  // Pull in the next two radicand bits and test root*4+1 against the remainder so extended.
  always_comb begin
    shifted  = {in_rem, in_rad[RAD_W-1 -: 2]};
    trial    = {{(SQ_REM_W-ROOT_W){1'b0}}, in_root, 2'b01};
    diff     = shifted - trial;
    ge       = (shifted >= trial);
    rem_nxt  = ge ? diff[SQ_REM_W-1:0] : shifted[SQ_REM_W-1:0];
    root_nxt = {in_root[ROOT_W-2:0], ge};
    rad_nxt  = {in_rad[RAD_W-3:0], 2'b00};
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side_r <= in_side;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_side  = side_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;

endmodule

`default_nettype wire

/* sv/stsr_checker.sv */
// ----------------------------------------------------------------------------
// stsr_checker
// Port-level checks of the response block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stick_trigger_sqrt_response_assert.svh"

module stsr_checker #(
  parameter int SAMPLE_BITS = stsr_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [SAMPLE_BITS-1:0]            in_adc_sample,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [stsr_pkg::AXIS_W-1:0] out_axis_value,
  input wire logic                              cfg_we,
  input wire logic [stsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input wire logic [stsr_pkg::CFG_W-1:0]        cfg_data
);
  import stsr_pkg::*;

  logic mode_r, mode_nxt;
  logic oe_r, oe_nxt;
  logic unused_in;

  assign unused_in = in_valid ^ (^in_adc_sample);

  // Shadow copies of the mode and enable registers.
  always_comb begin
    mode_nxt = mode_r;
    oe_nxt   = oe_r;
    if (cfg_we && (cfg_index == REG_CURVE_MODE)) begin
      mode_nxt = cfg_data[0];
    end
    if (cfg_we && (cfg_index == REG_OUTPUT_ENABLE)) begin
      oe_nxt = cfg_data[0] | (unused_in & 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STICK;
      oe_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      oe_r   <= oe_nxt;
    end
  end

  // A stalled result beat holds its value.
  `STSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_axis_value), "result beat changed while stalled")

  // An empty or draining output stage lets the whole pipeline move.
  `STSR_ASSERT_NOW(a_in_ready, !out_valid || out_ready,
    in_ready, "input stalled while the output stage can move")

  // With output disabled every result is zero.
  `STSR_ASSERT_NOW(a_disabled_zero, out_valid && !oe_r,
    out_axis_value == AXIS_ZERO, "nonzero result while output disabled")

  // Trigger depth stays within 0..255.
  `STSR_ASSERT_NOW(a_trigger_range, out_valid && (mode_r == MODE_TRIGGER),
    out_axis_value[AXIS_W-1:8] == '0, "trigger depth out of range")

endmodule

bind stick_trigger_sqrt_response stsr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_stsr_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for stick_trigger_sqrt_response
// Drives ADC samples through the square-root response block under several
// calibrations in both stick and trigger mode. It predicts each report value
// with an exact integer model of the curve and checks every output beat in
// order. Both channels idle at random, and the receiver holds off once for a
// long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import stsr_pkg::*;

  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam longint unsigned NEG_KSQ  = 64'd32768 * 64'd32768;
  localparam longint unsigned POS_KSQ  = 64'd32767 * 64'd32767;
  localparam longint unsigned TRIG_KSQ = 64'd255 * 64'd255;
  localparam int LONG_HOLD  = 200;
  localparam int DRAIN_WAIT = 60;

  logic                       clk;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic [SAMPLE_W-1:0]        in_adc_sample = '0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic signed [AXIS_W-1:0]   out_axis_value;
  logic                       cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index     = '0;
  logic [CFG_W-1:0]           cfg_data      = '0;

  // Random idling on both channels; cleared for the last part of the run.
  bit idling       = 1'b1;
  bit hold_off_req = 1'b0;

  logic [SAMPLE_W-1:0] pts[$];

  // Tracks the calibration and the report values still owed by the block.
  class axis_value_board;
    cfg_t                     cal;
    logic signed [AXIS_W-1:0] pending_values[$];
    int                       mismatches;

    function new();
      cal.curve_mode    = MODE_STICK;
      cal.cal_low       = CAL_LOW_RST;
      cal.cal_center    = CAL_CENTER_RST;
      cal.cal_high      = CAL_HIGH_RST;
      cal.output_enable = 1'b0;
      mismatches        = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CURVE_MODE: begin
          cal.curve_mode = data[0];
        end
        REG_CAL_LOW: begin
          cal.cal_low = data;
        end
        REG_CAL_CENTER: begin
          cal.cal_center = data;
        end
        REG_CAL_HIGH: begin
          cal.cal_high = data;
        end
        REG_OUTPUT_ENABLE: begin
          cal.output_enable = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    // Integer square root, rounded down, by the usual two-bit search.
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // floor(sqrt(n/d) * K), with the square of K given.
    function int scaled_root(int unsigned n, int unsigned d, longint unsigned ksq);
      longint unsigned q;
      q = (longint'(n) * ksq) / longint'(d);
      return int'(root_floor(q));
    endfunction

    function logic signed [AXIS_W-1:0] curve_value(logic [SAMPLE_W-1:0] sample);
      int unsigned x;
      int unsigned lo;
      int unsigned mid;
      int unsigned hi;
      int          v;
      x   = sample;
      lo  = cal.cal_low;
      mid = cal.cal_center;
      hi  = cal.cal_high;
      if (!cal.output_enable) begin
        v = 0;
      end else if (cal.curve_mode == MODE_STICK) begin
        if (x < lo) v = -32768;
        else if (x < mid) v = -scaled_root(mid - x, mid - lo, NEG_KSQ);
        else if (x < hi) v = scaled_root(x - mid, hi - mid, POS_KSQ);
        else v = 32767;
      end else begin
        if (x < lo) v = 0;
        else if (x < hi) v = scaled_root(x - lo, hi - lo, TRIG_KSQ);
        else v = 255;
      end
      return 16'(v);
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] sample);
      pending_values.push_back(curve_value(sample));
    endfunction

    function void check_value(logic signed [AXIS_W-1:0] actual);
      logic signed [AXIS_W-1:0] want;
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: axis_value %0d", actual);
        return;
      end
      want = pending_values.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("axis_value mismatch: expected %0d, got %0d", want, actual);
      end
    endfunction

    function int pending();
      return pending_values.size();
    endfunction
  endclass

  axis_value_board board = new();

  stick_trigger_sqrt_response u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_adc_sample  (in_adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_axis_value (out_axis_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock, period 2.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: checks each output beat and stalls in short bursts, plus one
  // long hold-off when the stimulus asks for it.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_value(out_axis_value);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic cfg_t calibration(logic mode, int lo, int mid, int hi, logic oe);
    cfg_t c;
    c.curve_mode    = mode;
    c.cal_low       = CFG_W'(lo);
    c.cal_center    = CFG_W'(mid);
    c.cal_high      = CFG_W'(hi);
    c.output_enable = oe;
    return c;
  endfunction

  // Mostly ordered calibrations, with disordered, full-span and collapsed ones.
  function automatic cfg_t random_calibration();
    logic [CFG_W-1:0] a;
    logic [CFG_W-1:0] b;
    logic [CFG_W-1:0] m;
    logic [CFG_W-1:0] t;
    cfg_t             c;
    a = CFG_W'($urandom);
    b = CFG_W'($urandom);
    m = CFG_W'($urandom);
    case ($urandom_range(0, 5))
      0: begin
      end
      1: begin
        a = '0;
        b = '1;
      end
      2: begin
        b = a;
        m = a;
      end
      default: begin
        if (a > m) begin t = a; a = m; m = t; end
        if (m > b) begin t = m; m = b; b = t; end
        if (a > m) begin t = a; a = m; m = t; end
      end
    endcase
    c.curve_mode    = logic'($urandom_range(0, 1));
    c.cal_low       = a;
    c.cal_center    = m;
    c.cal_high      = b;
    c.output_enable = ($urandom_range(0, 7) != 0);
    return c;
  endfunction

  // Samples cluster around the calibration points or sit at either extreme; the rest spread evenly.
  function automatic logic [SAMPLE_W-1:0] pick_sample(cfg_t c);
    logic [SAMPLE_W-1:0] base;
    case ($urandom_range(0, 7))
      3: base = c.cal_low;
      4: base = c.cal_center;
      5: base = c.cal_high;
      6: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return SAMPLE_W'($urandom);
    endcase
    return base + SAMPLE_W'($urandom_range(0, 4)) - SAMPLE_W'(2);
  endfunction

  task automatic put_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Writes all five registers on back-to-back edges; only called while idle.
  task automatic load_calibration(input cfg_t c);
    put_reg(REG_CURVE_MODE, CFG_W'(c.curve_mode));
    put_reg(REG_CAL_LOW, c.cal_low);
    put_reg(REG_CAL_CENTER, c.cal_center);
    put_reg(REG_CAL_HIGH, c.cal_high);
    put_reg(REG_OUTPUT_ENABLE, CFG_W'(c.output_enable));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one sample beat and returns at the edge that accepts it.
  task automatic offer_sample(input logic [SAMPLE_W-1:0] x);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= x;
    do @(posedge clk); while (!in_ready);
    board.note_sample(x);
  endtask

  // Stops offering and waits until every owed report value has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic run_points();
    foreach (pts[i]) offer_sample(pts[i]);
    drain();
  endtask

  initial begin : stimulus
    cfg_t c;
    int   count;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration leaves the output disabled.
    pts = {12'd0, 12'd4095};
    run_points();

    // Full-span stick axis: both ends and both sides of the center.
    load_calibration(calibration(MODE_STICK, 0, 2048, 4095, 1'b1));
    pts = {12'd0, 12'd1, 12'd2047, 12'd2048, 12'd2049, 12'd4094, 12'd4095};
    run_points();

    // Narrow stick span with dead zones below low and above high.
    load_calibration(calibration(MODE_STICK, 1000, 3000, 3500, 1'b1));
    pts = {12'd999, 12'd1000, 12'd3499, 12'd3500};
    run_points();

    // Disordered calibration: center below low, then high below center.
    load_calibration(calibration(MODE_STICK, 2000, 1000, 3000, 1'b1));
    pts = {12'd1999, 12'd2000, 12'd2500};
    run_points();
    load_calibration(calibration(MODE_STICK, 0, 3000, 1000, 1'b1));
    pts = {12'd3000, 12'd4095};
    run_points();

    // Trigger mode ignores the center register.
    load_calibration(calibration(MODE_TRIGGER, 100, 4095, 4000, 1'b1));
    pts = {12'd0, 12'd99, 12'd100, 12'd3999, 12'd4000, 12'd4095};
    run_points();

    // Random phases, each under its own calibration.
    for (int p = 0; p < 16; p++) begin
      case (p)
        1: c = calibration(MODE_TRIGGER, 0, 2048, 4095, 1'b1);
        2: c = calibration(MODE_STICK, 0, 0, 4095, 1'b1);
        3: c = calibration(MODE_STICK, 0, 4095, 4095, 1'b1);
        default: c = random_calibration();
      endcase
      if (p == 5) begin
        c.output_enable = 1'b1;
        hold_off_req    = 1'b1;
      end
      if (p >= 13) idling = 1'b0;
      load_calibration(c);
      count = (p == 5) ? 400 : 92;
      repeat (count) offer_sample(pick_sample(c));
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/stsr_pkg.sv
sv/stsr_front.sv
sv/stsr_div_step.sv
sv/stsr_sqrt_step.sv
sv/stick_trigger_sqrt_response.sv
sv/stsr_checker.sv
bench/testbench.sv
